### hw/rtl/mks_pkg.sv
`default_nettype none

package mks_pkg;

  typedef enum logic [2:0] {
    PhaseScan     = 3'b001,
    PhaseDebounce = 3'b010,
    PhaseRelease  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    CfgLayoutSelect = 2'd0,
    CfgDebounceTicks = 2'd1,
    CfgPressedLevel = 2'd2
  } cfg_index_e;

  localparam int unsigned CfgDataWidth = 16;
  localparam logic [15:0] DebounceTicksReset = 16'd20;
  localparam logic [2:0] CursorNone = 3'd4;

  typedef struct packed {
    logic        layout_select;
    logic [15:0] debounce_ticks;
    logic        pressed_level;
  } mks_cfg_t;

  typedef struct packed {
    logic [1:0]  row_index;
    phase_e      scan_phase;
    logic [15:0] debounce_count;
    logic [1:0]  held_column;
    logic [2:0]  column_cursor;
  } mks_state_t;

  typedef struct packed {
    logic [3:0] column_levels;
  } mks_in_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [7:0] key_code;
  } mks_out_t;

  localparam logic [7:0] KeyTable [2][4][4] = '{
    '{
      '{8'h31, 8'h32, 8'h33, 8'h41},
      '{8'h34, 8'h35, 8'h36, 8'h42},
      '{8'h37, 8'h38, 8'h39, 8'h43},
      '{8'h2A, 8'h30, 8'h23, 8'h44}
    },
    '{
      '{8'h37, 8'h38, 8'h39, 8'h2F},
      '{8'h34, 8'h35, 8'h36, 8'h2A},
      '{8'h31, 8'h32, 8'h33, 8'h2D},
      '{8'h43, 8'h30, 8'h3D, 8'h2B}
    }
  };

endpackage

`default_nettype wire

### hw/rtl/mks_stream_if.sv
`default_nettype none

interface mks_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

### hw/rtl/matrix_keypad_scanner.sv
// Scanner for a 4x4 key matrix, advanced by one column sample per transfer.
// The input channel col_i carries the four column levels sampled while the
// row given by the matching result's row_drive was driven low. Every input
// transfer yields exactly one result transfer on key_o with row_drive,
// key_valid and key_code; key_code is nonzero only on the sample at which a
// debounced key is seen released.
// Each result is registered into the output queue and offered from there.
// The state update is a single short pass of logic per sample, so one item
// is taken every cycle while results are drained.
// Results wait in a two-entry output queue, so an input transfer can still
// complete while a finished result is stalled. When the receiver holds off
// and both entries are full, col_i.ready drops until one result leaves.
// Configuration writes (layout, debounce length, pressed level) land on the
// cycle of cfg_we_i and should be made while no result is pending.
// Reset clears the scan state to row 0 scanning, empties the queue and
// restores the telephone layout, a debounce length of 20 and active-low keys.
`default_nettype none

module matrix_keypad_scanner
  import mks_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  mks_stream_if.sink                   col_i,
  mks_stream_if.source                 key_o
);

  mks_cfg_t   cfg_q;
  mks_state_t state_q, state_d;
  mks_out_t   result_d;
  mks_out_t   res_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout_select  <= 1'b0;
      cfg_q.debounce_ticks <= DebounceTicksReset;
      cfg_q.pressed_level  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLayoutSelect:  cfg_q.layout_select  <= cfg_wdata_i[0];
        CfgDebounceTicks: cfg_q.debounce_ticks <= cfg_wdata_i;
        CfgPressedLevel:  cfg_q.pressed_level  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  mks_step u_step (
    .cfg_i           (cfg_q),
    .state_i         (state_q),
    .column_levels_i (col_i.data.column_levels),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  assign col_i.ready = (cnt_q != 2'd2);
  assign push        = col_i.valid && col_i.ready;
  assign key_o.valid = (cnt_q != 2'd0);
  assign key_o.data  = res_q[rd_ptr_q];
  assign pop         = key_o.valid && key_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.row_index      <= 2'd0;
      state_q.scan_phase     <= PhaseScan;
      state_q.debounce_count <= 16'd0;
      state_q.held_column    <= 2'd0;
      state_q.column_cursor  <= 3'd0;
      wr_ptr_q               <= 1'b0;
      rd_ptr_q               <= 1'b0;
      cnt_q                  <= 2'd0;
    end else begin
      if (push) begin
        state_q  <= state_d;
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_ptr_q] <= result_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("Result queue count out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q.scan_phase) && (state_q.column_cursor <= CursorNone))
    else $error("Scan state is corrupt.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_o.valid |-> (key_o.data.key_valid == (key_o.data.key_code != 8'd0)))
    else $error("Key code does not agree with key_valid.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_o.valid |-> ($countones(~key_o.data.row_drive) == 1))
    else $error("Row drive must select exactly one row.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (state_q.scan_phase == PhaseRelease) && result_d.key_valid)
      |=> (state_q.scan_phase == PhaseScan) && (state_q.column_cursor == 3'd0))
    else $error("Release did not return to scanning.");

endmodule

`default_nettype wire

### hw/rtl/mks_step.sv
`default_nettype none

module mks_step
  import mks_pkg::*;
(
  input  mks_cfg_t   cfg_i,
  input  mks_state_t state_i,
  input  logic [3:0] column_levels_i,
  output mks_state_t state_o,
  output mks_out_t   result_o
);

  logic [3:0] pressed;
  logic       held_pressed;
  logic       found;
  logic [1:0] found_col;

  assign pressed      = cfg_i.pressed_level ? column_levels_i : ~column_levels_i;
  assign held_pressed = pressed[state_i.held_column];

  always_comb begin
    found     = 1'b0;
    found_col = 2'd0;
    for (int c = 3; c >= 0; c--) begin
      if (pressed[c] && (3'(c) >= state_i.column_cursor)) begin
        found     = 1'b1;
        found_col = 2'(c);
      end
    end
  end

  always_comb begin
    state_o            = state_i;
    result_o.row_drive = ~(4'b0001 << state_i.row_index);
    result_o.key_valid = 1'b0;
    result_o.key_code  = 8'd0;
    unique case (state_i.scan_phase)
      PhaseDebounce: begin
        if (state_i.debounce_count > 16'd1) begin
          state_o.debounce_count = state_i.debounce_count - 16'd1;
        end else begin
          state_o.debounce_count = 16'd0;
          if (held_pressed) begin
            state_o.scan_phase = PhaseRelease;
          end else begin
            state_o.column_cursor = {1'b0, state_i.held_column} + 3'd1;
            state_o.scan_phase    = PhaseScan;
          end
        end
      end
      PhaseRelease: begin
        if (!held_pressed) begin
          result_o.key_valid =
            1'b1;
          result_o.key_code =
            KeyTable[cfg_i.layout_select][state_i.row_index][state_i.held_column];
          state_o.row_index     = state_i.row_index + 2'd1;
          state_o.column_cursor = 3'd0;
          state_o.scan_phase    = PhaseScan;
        end
      end
      default: begin
        if (found) begin
          state_o.held_column    = found_col;
          state_o.debounce_count = cfg_i.debounce_ticks;
          state_o.scan_phase     = PhaseDebounce;
        end else begin
          state_o.row_index     = state_i.row_index + 2'd1;
          state_o.column_cursor = 3'd0;
          state_o.scan_phase    = PhaseScan;
        end
      end
    endcase
  end

endmodule

`default_nettype wire
